@@ rtl/core/lr_pkg.sv @@
// shared types and constants for the line rasterizer
`default_nettype none

package lr_pkg;

  localparam int FIELD_BITS   = 16;
  localparam int COLOR_BITS   = 8;
  localparam int REG_IDX_BITS = 1;

  localparam logic [FIELD_BITS-1:0] FRAME_WIDTH_RESET  = 16'd640;
  localparam logic [FIELD_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;

  // register indexes on the config port
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [1:0] {
    MODE_STEEP_UP     = 2'd0,
    MODE_STEEP_DOWN   = 2'd1,
    MODE_SHALLOW_UP   = 2'd2,
    MODE_SHALLOW_DOWN = 2'd3
  } mode_t;

  typedef struct packed {
    logic                  kind;
    logic [FIELD_BITS-1:0] x_first;
    logic [FIELD_BITS-1:0] x_second;
    logic [FIELD_BITS-1:0] y_first;
    logic [FIELD_BITS-1:0] y_second;
    logic [COLOR_BITS-1:0] red_in;
    logic [COLOR_BITS-1:0] green_in;
    logic [COLOR_BITS-1:0] blue_in;
  } item_t;

  typedef struct packed {
    logic                  pixel_valid;
    logic [FIELD_BITS-1:0] pixel_x;
    logic [FIELD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] red_out;
    logic [COLOR_BITS-1:0] green_out;
    logic [COLOR_BITS-1:0] blue_out;
    logic                  last_pixel;
  } result_t;

  typedef struct packed {
    logic [REG_IDX_BITS-1:0] index;
    logic [FIELD_BITS-1:0]   value;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] width;
    logic [FIELD_BITS-1:0] height;
  } frame_t;

endpackage

`default_nettype wire

@@ rtl/core/lr_stream_if.sv @@
// valid/ready channel carrying one payload item
`default_nettype none

interface lr_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ rtl/core/lr_cfg_regs.sv @@
// frame size configuration registers
`default_nettype none

module lr_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  lr_stream_if.sink          cfg,
  output lr_pkg::frame_t     frame
);

  import lr_pkg::*;

  logic [FIELD_BITS-1:0] frame_width;
  logic [FIELD_BITS-1:0] frame_height;

  assign cfg.ready    = 1'b1;
  assign frame.width  = frame_width;
  assign frame.height = frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data.value;
        REG_FRAME_HEIGHT: frame_height <= cfg.data.value;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lr_walker.sv @@
// line state and combinational step logic
`default_nettype none

module lr_walker #(
  parameter int COORD_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  lr_pkg::item_t      item,
  input  lr_pkg::frame_t     frame,
  output lr_pkg::result_t    res
);

  import lr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DB = COORD_BITS + 2;  // endpoint deltas
  localparam int EB = COORD_BITS + 4;  // error term and its candidates

  // line state
  logic                  active;
  logic [CB-1:0]         cur_x;
  logic [CB-1:0]         cur_y;
  logic [CB-1:0]         tgt_x;
  logic [CB-1:0]         tgt_y;
  mode_t                 mode;
  logic [3*COLOR_BITS-1:0] color;
  logic signed [DB-1:0]  dx;
  logic signed [DB-1:0]  dy;
  logic signed [EB-1:0]  err;

  // start path
  logic [CB-1:0]         xa, xb, ya, yb;
  logic [CB-1:0]         ox, oy, tx, ty;
  logic signed [DB-1:0]  sdx, sdy;
  mode_t                 smode;
  logic                  s_more;

  // step path
  logic signed [EB-1:0]  dxe, dye;
  logic signed [EB-1:0]  base, alt;
  logic                  take;
  logic [CB-1:0]         nx, ny;
  logic signed [EB-1:0]  err_next;
  logic                  n_more;

  function automatic logic [EB-1:0] mag(input logic signed [EB-1:0] v);
    mag = v[EB-1] ? unsigned'(-v) : unsigned'(v);
  endfunction

  function automatic logic may_go(input logic [CB-1:0] x, input logic [CB-1:0] y,
                                  input logic [CB-1:0] ex, input logic [CB-1:0] ey,
                                  input mode_t m, input frame_t f);
    logic in_frame;
    in_frame = (FIELD_BITS'(x) < f.width) && (FIELD_BITS'(y) < f.height);
    case (m)
      MODE_STEEP_UP:   may_go = in_frame && (y < ey);
      MODE_STEEP_DOWN: may_go = in_frame && (y > ey);
      default:         may_go = in_frame && ((x < ex) || (y < ey));
    endcase
  endfunction

  always_comb begin
    xa = item.x_first[CB-1:0];
    xb = item.x_second[CB-1:0];
    ya = item.y_first[CB-1:0];
    yb = item.y_second[CB-1:0];
    if (xa > xb) begin
      ox = xb; oy = yb; tx = xa; ty = ya;
    end else begin
      ox = xa; oy = ya; tx = xb; ty = yb;
    end
    sdx = signed'({2'b00, tx}) - signed'({2'b00, ox});
    sdy = signed'({2'b00, ty}) - signed'({2'b00, oy});
    if (sdx <= sdy) begin
      smode = MODE_STEEP_UP;
    end else if (!sdy[DB-1]) begin
      smode = MODE_SHALLOW_UP;
    end else if (sdx < -sdy) begin
      smode = MODE_STEEP_DOWN;
    end else begin
      smode = MODE_SHALLOW_DOWN;
    end
    s_more = may_go(ox, oy, tx, ty, smode, frame);
  end

  // err holds u*dy - v*dx for the current pixel, kept up incrementally
  assign dxe = EB'(dx);
  assign dye = EB'(dy);

  always_comb begin
    nx = cur_x;
    ny = cur_y;
    case (mode)
      MODE_STEEP_UP: begin
        base = err - dxe;
        alt  = base + dye;
        take = !(mag(base) < mag(alt));
        ny   = cur_y + 1'b1;
        if (take) nx = cur_x + 1'b1;
      end
      MODE_STEEP_DOWN: begin
        base = err + dxe;
        alt  = base + dye;
        take = !(mag(base) < mag(alt));
        ny   = cur_y - 1'b1;
        if (take) nx = cur_x + 1'b1;
      end
      MODE_SHALLOW_UP: begin
        base = err + dye;
        alt  = base - dxe;
        take = mag(alt) < mag(base);
        nx   = cur_x + 1'b1;
        if (take) ny = cur_y + 1'b1;
      end
      default: begin
        base = err + dye;
        alt  = base + dxe;
        take = mag(alt) < mag(base);
        nx   = cur_x + 1'b1;
        if (take) ny = cur_y - 1'b1;
      end
    endcase
    err_next = take ? alt : base;
    n_more   = may_go(nx, ny, tgt_x, tgt_y, mode, frame);
  end

  always_comb begin
    if (item.kind == KIND_START) begin
      res.pixel_valid = 1'b1;
      res.pixel_x     = FIELD_BITS'(ox);
      res.pixel_y     = FIELD_BITS'(oy);
      res.red_out     = item.red_in;
      res.green_out   = item.green_in;
      res.blue_out    = item.blue_in;
      res.last_pixel  = !s_more;
    end else if (active) begin
      res.pixel_valid = 1'b1;
      res.pixel_x     = FIELD_BITS'(nx);
      res.pixel_y     = FIELD_BITS'(ny);
      res.red_out     = color[3*COLOR_BITS-1:2*COLOR_BITS];
      res.green_out   = color[2*COLOR_BITS-1:COLOR_BITS];
      res.blue_out    = color[COLOR_BITS-1:0];
      res.last_pixel  = !n_more;
    end else begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (fire) begin
      if (item.kind == KIND_START) begin
        active <= s_more;
      end else if (active) begin
        active <= n_more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (item.kind == KIND_START) begin
        cur_x <= ox;
        cur_y <= oy;
        tgt_x <= tx;
        tgt_y <= ty;
        dx    <= sdx;
        dy    <= sdy;
        mode  <= smode;
        color <= {item.red_in, item.green_in, item.blue_in};
        err   <= '0;
      end else if (active) begin
        cur_x <= nx;
        cur_y <= ny;
        err   <= err_next;
      end
    end
  end

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.pixel_valid && res.last_pixel |=> !active)
    else $error("line still active after last pixel");

  a_steep_up_below_target: assert property (@(posedge clk) disable iff (rst)
    active && (mode == MODE_STEEP_UP) |-> cur_y < tgt_y)
    else $error("steep up line active at or past target row");

  a_start_clears_error: assert property (@(posedge clk) disable iff (rst)
    fire && (item.kind == KIND_START) |=> err == '0)
    else $error("error term not cleared on line start");

  a_idle_tick_empty: assert property (@(posedge clk) disable iff (rst)
    !active && (item.kind == KIND_TICK) |-> res == '0)
    else $error("tick while idle produced a pixel");

endmodule

`default_nettype wire

@@ rtl/core/line_rasterizer_core.sv @@
// line rasterizer top level: input register, walker, result register
//
//  channel    dir  payload                                     handshake
//  item_in    in   kind, endpoints, color                      valid/ready
//  pixel_out  out  pixel_valid, x, y, color, last_pixel        valid/ready
//  cfg        in   register index, 16-bit value                valid/ready
//
// each item yields one result item via the input and result registers; one item per
// cycle while pixel_out.ready is high, set by the step loop in the walker
// reset (rst, synchronous) empties both registers, ends any line and loads 640 x 480
// a stalled result register holds the next item in the input register and then
// drops item_in.ready; cfg.ready is always high

`default_nettype none

module line_rasterizer_core #(
  parameter int COORD_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  lr_stream_if.sink   item_in,
  lr_stream_if.source pixel_out,
  lr_stream_if.sink   cfg
);

  import lr_pkg::*;

  frame_t  frame;
  logic    stage_valid;
  item_t   stage_item;
  logic    res_valid;
  result_t res;
  result_t walk_res;
  logic    adv;

  assign adv           = stage_valid && (!res_valid || pixel_out.ready);
  assign item_in.ready = !stage_valid || adv;
  assign pixel_out.valid = res_valid;
  assign pixel_out.data  = res;

  lr_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .frame (frame)
  );

  lr_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk   (clk),
    .rst   (rst),
    .fire  (adv),
    .item  (stage_item),
    .frame (frame),
    .res   (walk_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (item_in.valid && item_in.ready) begin
        stage_valid <= 1'b1;
      end else if (adv) begin
        stage_valid <= 1'b0;
      end
      if (adv) begin
        res_valid <= 1'b1;
      end else if (pixel_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      stage_item <= item_in.data;
    end
    if (adv) begin
      res <= walk_res;
    end
  end

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !adv |=> stage_valid && $stable(stage_item))
    else $error("staged item lost while result stalled");

  a_adv_fills_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> res_valid)
    else $error("result register empty after advance");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !pixel_out.ready |-> !adv)
    else $error("stalled result overwritten");

endmodule

`default_nettype wire
